/* hdl/wiidec_pkg.sv */
package wiidec_pkg;

    localparam int REPORT_BYTES = 8;
    localparam int AXIS_W       = 16;
    localparam int TRIG_W       = 12;
    localparam int BTN_W        = 13;
    localparam int CFG_DEV_IDX  = 0;

    localparam logic [15:0] DRUM_BTN_MASK  = 16'hFEFF;
    localparam logic [15:0] TABLE_BTN_MASK = 16'h63CD;

    typedef enum logic [3:0] {
        DEV_NONE      = 4'd0,
        DEV_GUITAR    = 4'd1,
        DEV_CLASSIC   = 4'd2,
        DEV_NUNCHUK   = 4'd3,
        DEV_DRUMS     = 4'd4,
        DEV_UDRAW     = 4'd5,
        DEV_DRAWSOME  = 4'd6,
        DEV_TURNTABLE = 4'd7,
        DEV_TAIKO     = 4'd8
    } dev_type_t;

    // button bit positions in the result word
    localparam int BTN_X = 10;
    localparam int BTN_A = 9;
    localparam int BTN_B = 11;

    typedef logic [7:0] report_t [REPORT_BYTES];

    typedef struct packed {
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
        logic [TRIG_W-1:0] left_trigger;
        logic [TRIG_W-1:0] right_trigger;
        logic [BTN_W-1:0]  button_bits;
    } held_t;

    // source bit of the packed device word for each result button
    localparam logic [3:0] BTN_SRC [BTN_W] = '{
        4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    function automatic logic [BTN_W-1:0] remap_buttons(input logic [15:0] w);
        logic [BTN_W-1:0] r;
        for (int j = 0; j < BTN_W; j++) begin
            r[j] = w[BTN_SRC[j]];
        end
        return r;
    endfunction

endpackage

/* hdl/wii_extension_report_decoder_unit.sv */
// Wii extension report decoder.
// s_ channel: one word per 8-byte extension report, bytes in tdata (byte 0 in
// the low bits), tuser carries the bus read-error flag.
// m_ channel: one word per report with the decoded axes, triggers and buttons
// in tdata and report_ok in tuser. Fields a device does not drive keep the
// values of the previous word.
// APB port: device_type register at byte address 0, to be written only while
// idle; the block itself does not enforce this. Each input word passes the
// input register, then is decoded into the result register, which drives
// m_tvalid. One report per cycle while the receiver does not stall.
// The result register doubles as the held state, so the decode is one pass
// of logic between the two registers.
// When the receiver stalls, the result holds and one more report is taken
// into the input register; s_tready drops only when both are full.
// Reset clears device_type, all held fields and both valid flags.
module wii_extension_report_decoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // APB
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input reports
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // byte0..byte7, 8 bits each
    input  logic         s_tuser,   // read_error
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // left_x, left_y, right_x, right_y (16 each),
                                    // left_trigger, right_trigger (12 each),
                                    // button_bits (13), zero pad (3)
    output logic         m_tuser    // report_ok
);
    import wiidec_pkg::*;

    dev_type_t   device_type;
    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        in_err_reg;
    logic        out_valid_reg;
    logic        out_ok_reg;
    held_t       held_reg;
    held_t       held_next;
    logic        ok_next;
    logic        advance;
    report_t     rpt;

    wiidec_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .device_type (device_type)
    );

    always_comb begin
        for (int i = 0; i < REPORT_BYTES; i++) begin
            rpt[i] = in_data_reg[8*i +: 8];
        end
    end

    wiidec_decode u_decode (
        .device_type (device_type),
        .rpt         (rpt),
        .read_error  (in_err_reg),
        .held        (held_reg),
        .held_next   (held_next),
        .report_ok   (ok_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_err_reg  <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            held_reg      <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                out_ok_reg    <= ok_next;
                held_reg      <= held_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {3'd0,
                       held_reg.button_bits,
                       held_reg.right_trigger,
                       held_reg.left_trigger,
                       held_reg.right_y,
                       held_reg.right_x,
                       held_reg.left_y,
                       held_reg.left_x};

endmodule

/* hdl/wiidec_cfg_regs.sv */
module wiidec_cfg_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output wiidec_pkg::dev_type_t  device_type
);
    import wiidec_pkg::*;

    logic [3:0] dev_type_reg;
    logic       wr_en;
    logic       sel_dev;

    assign pready  = 1'b1;
    assign sel_dev = (paddr[2] == 1'(CFG_DEV_IDX));
    assign wr_en   = psel && penable && pwrite && sel_dev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_type_reg <= 4'd0;
        end else if (wr_en) begin
            dev_type_reg <= pwdata[3:0];
        end
    end

    assign prdata      = sel_dev ? {28'd0, dev_type_reg} : 32'd0;
    assign device_type = dev_type_t'(dev_type_reg);

endmodule

/* hdl/wiidec_decode.sv */
module wiidec_decode (
    input  wiidec_pkg::dev_type_t device_type,
    input  wiidec_pkg::report_t   rpt,
    input  logic                  read_error,
    input  wiidec_pkg::held_t     held,
    output wiidec_pkg::held_t     held_next,
    output logic                  report_ok
);
    import wiidec_pkg::*;

    logic       any_set;
    logic       all_set;
    logic [4:0] tt_left;
    logic [4:0] tt_right;

    always_comb begin
        any_set = 1'b0;
        all_set = 1'b1;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            any_set = any_set | (|rpt[i]);
            all_set = all_set & (&rpt[i]);
        end
    end

    assign report_ok = !read_error && any_set && !all_set;

    assign tt_left  = rpt[3][4:0];
    assign tt_right = {rpt[0][7:6], rpt[1][7:6], rpt[2][7]};

    // centered values: (v - 0x80) << 8 keeps only v ^ 0x80 in the top byte,
    // (v - 0x20) << 10 keeps only the low six bits of the difference
    always_comb begin
        held_next = held;
        if (report_ok) begin
            case (device_type)
                DEV_GUITAR: begin
                    held_next.left_x      = {rpt[0] ^ 8'h80, 8'h00};
                    held_next.left_y      = {rpt[2] ^ 8'h80, 8'h00};
                    // whammy clamps low at zero; the high end never exceeds 0x7F00
                    held_next.right_x     = rpt[5][7] ? {1'b0, rpt[5][6:0], 8'h00} : 16'd0;
                    held_next.button_bits = remap_buttons(~{rpt[7], rpt[6]});
                end
                DEV_CLASSIC: begin
                    held_next.left_x        = {rpt[0] ^ 8'h80, 8'h00};
                    held_next.left_y        = {rpt[2] ^ 8'h80, 8'h00};
                    held_next.right_x       = {rpt[1] ^ 8'h80, 8'h00};
                    held_next.right_y       = {rpt[3] ^ 8'h80, 8'h00};
                    held_next.left_trigger  = {4'd0, rpt[4]};
                    held_next.right_trigger = {4'd0, rpt[5]};
                    held_next.button_bits   = remap_buttons(~{rpt[7], rpt[6]});
                end
                DEV_NUNCHUK: begin
                    held_next.left_x             = {rpt[0] ^ 8'h80, 8'h00};
                    held_next.left_y             = {rpt[2] ^ 8'h80, 8'h00};
                    held_next.button_bits[BTN_A] = !rpt[5][0];
                    held_next.button_bits[BTN_B] = !rpt[5][1];
                end
                DEV_DRUMS: begin
                    held_next.left_x      = {rpt[0][5:0] ^ 6'h20, 10'd0};
                    held_next.left_y      = {rpt[1][5:0] ^ 6'h20, 10'd0};
                    held_next.button_bits =
                        remap_buttons(~{rpt[5], rpt[4]} & DRUM_BTN_MASK);
                end
                DEV_UDRAW: begin
                    held_next.left_x             = {4'd0, rpt[2][3:0], rpt[0]};
                    held_next.left_y             = {4'd0, rpt[2][7:4], rpt[1]};
                    held_next.right_trigger      = {4'd0, rpt[3]};
                    held_next.button_bits[BTN_A] = rpt[5][0];
                    held_next.button_bits[BTN_B] = rpt[5][1];
                    held_next.button_bits[BTN_X] = !rpt[5][2];
                end
                DEV_DRAWSOME: begin
                    held_next.left_x        = {rpt[1], rpt[0]};
                    held_next.left_y        = {rpt[3], rpt[2]};
                    held_next.right_trigger = {rpt[5][3:0], rpt[4]};
                end
                DEV_TURNTABLE: begin
                    held_next.left_x        = {rpt[0][5:0] ^ 6'h20, 10'd0};
                    held_next.left_y        = {rpt[1][5:0] ^ 6'h20, 10'd0};
                    // 32 + (31 - v) is {1, ~v}; 32 - v stays positive
                    held_next.right_x       = rpt[4][0] ? {10'd0, 1'b1, ~tt_left}
                                                        : {10'd0, 6'd32 - {1'b0, tt_left}};
                    held_next.right_y       = rpt[2][0] ? {10'd0, 1'b1, ~tt_right}
                                                        : {10'd0, 6'd32 - {1'b0, tt_right}};
                    held_next.left_trigger  = {7'd0, rpt[2][6:5], rpt[3][7:5]};
                    held_next.right_trigger = {8'd0, rpt[2][4:1]};
                    held_next.button_bits   =
                        remap_buttons(~{rpt[4], rpt[5]} & TABLE_BTN_MASK);
                end
                DEV_TAIKO: begin
                    held_next.button_bits = remap_buttons(~{rpt[4], rpt[5]});
                end
                default: begin
                    held_next = held;
                end
            endcase
        end
    end

endmodule
